// ===== rtl/rras_pkg.sv =====
// package for the rolling average receptor statistics block
// shared constants, widths and pipeline state types; no dependencies
`default_nettype none
package rras_pkg;
	localparam int WINDOW_DEPTH_DEF = 8192;
	localparam int MAX_SERIES_DEF = 1048576;
	localparam int SAMPLE_W = 32;
	localparam int CFG_W = 32;
	localparam int SUM_W = 48;

	typedef enum logic [1:0] {
		REG_WINDOW_SIZE = 2'd0,
		REG_HOURLY_POLICY = 2'd1,
		REG_SCALE_FACTOR = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

	localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
	localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;

	// saturate a 64 bit signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v < 64'(MIN32))
			r = MIN32;
		else if (v > 64'(MAX32))
			r = MAX32;
		else
			r = v[31:0];
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/receptor_rolling_average_stats.sv =====
// top level of the rolling average receptor statistics block
// instantiates rras_ring and rras_divider; uses rras_pkg
//
// usage: input beats carry sample, calm_flag and last_of_receptor on a
// valid/stall channel. each sample is scaled, written to the ring window and
// one rolling average is divided out, and the largest is kept. a beat with
// last_of_receptor set yields one result beat with max rolling average,
// mean, maximum, variance and the divide fault flag, then clears series state.
// the input stalls while the bit serial divider works out a beat's rolling
// average (64 steps); a beat whose divisor is zero skips the divide.
// a last beat's result follows its own rolling average and two more
// divides for mean and square mean; the next beat is taken once the
// result has moved into the output register.
// the ring needs no clear, read data is used only for entries written since
// the window was last emptied.
// reset clears all control state and loads the register defaults.
// a stalled result holds in the output register while the next series runs;
// a second result waits inside and the input stalls until the first is taken.
// configuration writes are taken at any time but meant only when idle.
`default_nettype none
module receptor_rolling_average_stats
	import rras_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	parameter int MAX_SERIES = MAX_SERIES_DEF
)(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [31:0] sample,
	input wire logic calm_flag,
	input wire logic last_of_receptor,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [31:0] max_rolling_avg,
	output logic signed [31:0] mean_value,
	output logic signed [31:0] max_value,
	output logic [62:0] variance_value,
	output logic divide_fault
);
	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int FW = $clog2(WINDOW_DEPTH + 1);
	localparam int CW = $clog2(MAX_SERIES + 1);

	logic [13:0] wsize_q;
	logic hourly_q;
	logic [31:0] scale_q;

	state_t state_q, state_d;
	logic [1:0] phase_q;

	logic [AW-1:0] wptr_q;
	logic [FW-1:0] fill_q;
	logic signed [SUM_W-1:0] wsum_q;
	logic [FW-1:0] calm_cnt_q;
	logic signed [31:0] best_q;
	logic [CW-1:0] cnt_q;
	logic signed [63:0] ssum_q;
	logic [63:0] sqsum_q;
	logic signed [31:0] smax_q;
	logic fault_q;

	logic signed [31:0] sample_q;
	logic calm_q;
	logic last_q;
	logic signed [31:0] v_q;
	logic signed [31:0] mean_q;
	logic [63:0] e2_q;

	logic out_valid_q;
	logic out_load;
	logic signed [31:0] res_avg_q;
	logic signed [31:0] res_mean_q;
	logic signed [31:0] res_max_q;
	logic [62:0] res_var_q;
	logic res_fault_q;

	logic [FW-1:0] weff;
	logic [AW-1:0] ptr_use;
	logic [32:0] rd_data;
	logic wr_en;

	logic div_start, div_busy, div_done, div_floor;
	logic signed [63:0] div_num;
	logic [63:0] div_den;
	logic signed [31:0] div_quot;
	logic [63:0] div_uquot;

	logic accept_in;
	assign accept_in = in_valid && !in_stall;

	// result moves to the output register once that register is free
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// effective window clamp
	always_comb begin
		if (wsize_q == 14'd0)
			weff = FW'(1);
		else if (32'(wsize_q) > WINDOW_DEPTH)
			weff = FW'(WINDOW_DEPTH);
		else
			weff = FW'(wsize_q);
		ptr_use = (32'(wptr_q) >= 32'(weff)) ? '0 : wptr_q;
	end

	assign wr_en = (state_q == ST_READ) && (phase_q == 2'd1);

	rras_ring #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_ring (
		.clk(clk),
		.rd_en(state_q == ST_READ && phase_q == 2'd0),
		.rd_addr(ptr_use),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(ptr_use),
		.wr_data({calm_q, v_q})
	);

	rras_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.floor_div(div_floor),
		.num(div_num),
		.den(div_den),
		.busy(div_busy),
		.done(div_done),
		.quot(div_quot),
		.uquot(div_uquot)
	);

	// scaling
	logic signed [63:0] prod;
	logic signed [63:0] scaled;
	always_comb begin
		prod = 64'(sample_q) * $signed({32'd0, scale_q}) + 64'sd32768;
		scaled = prod >>> 16;
	end

	// window update values
	logic full;
	logic signed [SUM_W-1:0] nsum;
	logic [FW-1:0] nfill, ncalm, ndiv, lo;
	always_comb begin
		full = fill_q >= weff;
		nsum = wsum_q + SUM_W'(v_q);
		ncalm = calm_cnt_q + FW'(calm_q);
		nfill = fill_q;
		if (full) begin
			nsum = nsum - SUM_W'($signed(rd_data[31:0]));
			ncalm = ncalm - FW'(rd_data[32]);
		end else begin
			nfill = fill_q + FW'(1);
		end
		lo = FW'((34'(nfill) * 34'd3 + 34'd3) >> 2);
		if (hourly_q) begin
			ndiv = nfill - ncalm;
			if (32'(nfill) <= 24 && lo > ndiv)
				ndiv = lo;
		end else begin
			ndiv = nfill;
		end
	end

	logic signed [63:0] sq;
	assign sq = 64'(v_q) * 64'(v_q);

	logic [64:0] sqadd;
	assign sqadd = {1'b0, sqsum_q} + {1'b0, sq};

	logic signed [63:0] m2;
	logic [63:0] var_full;
	assign m2 = 64'(mean_q) * 64'(mean_q);
	assign var_full = (e2_q > m2) ? e2_q - m2 : 64'd0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept_in) state_d = ST_READ;
			ST_READ: if (phase_q == 2'd1)
				state_d = (ndiv == '0) ? (last_q ? ST_FIN : ST_IDLE) : ST_DIV;
			ST_DIV: if (div_done) state_d = last_q ? ST_FIN : ST_IDLE;
			ST_FIN: if (div_done && phase_q == 2'd2) state_d = ST_OUT;
			ST_OUT: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_valid = out_valid_q;
		div_start = 1'b0;
		div_floor = 1'b0;
		div_num = 64'(wsum_q);
		div_den = 64'(ndiv);
		if (state_q == ST_READ && phase_q == 2'd1 && ndiv != '0) begin
			div_start = 1'b1;
			div_num = 64'(nsum);
		end else if (state_q == ST_FIN && phase_q == 2'd0 && !div_busy) begin
			div_start = 1'b1;
			div_num = ssum_q;
			div_den = 64'(cnt_q);
		end else if (state_q == ST_FIN && phase_q == 2'd1 && !div_busy) begin
			// square mean is unsigned and floored
			div_start = 1'b1;
			div_floor = 1'b1;
			div_num = $signed(sqsum_q);
			div_den = 64'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsize_q <= 14'd24;
			hourly_q <= 1'b1;
			scale_q <= 32'd65536;
			state_q <= ST_IDLE;
			phase_q <= '0;
			wptr_q <= '0;
			fill_q <= '0;
			wsum_q <= '0;
			calm_cnt_q <= '0;
			best_q <= MIN32;
			cnt_q <= '0;
			ssum_q <= '0;
			sqsum_q <= '0;
			smax_q <= MIN32;
			fault_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WINDOW_SIZE: begin
						wsize_q <= cfg_data[13:0];
						wptr_q <= '0;
						fill_q <= '0;
						wsum_q <= '0;
						calm_cnt_q <= '0;
					end
					REG_HOURLY_POLICY: hourly_q <= cfg_data[0];
					REG_SCALE_FACTOR: scale_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: phase_q <= '0;
				ST_READ: begin
					phase_q <= (phase_q == 2'd1) ? '0 : phase_q + 2'd1;
					if (phase_q == 2'd1) begin
						wptr_q <= (32'(ptr_use) + 1 >= 32'(weff)) ? '0 : ptr_use + AW'(1);
						fill_q <= nfill;
						wsum_q <= nsum;
						calm_cnt_q <= ncalm;
						if (ndiv == '0)
							fault_q <= 1'b1;
						if (v_q > smax_q)
							smax_q <= v_q;
						if (32'(cnt_q) < MAX_SERIES) begin
							cnt_q <= cnt_q + CW'(1);
							ssum_q <= ssum_q + 64'(v_q);
							sqsum_q <= sqadd[64] ? '1 : sqadd[63:0];
						end
					end
				end
				// last beat's own rolling average lands when entering ST_FIN
				ST_DIV: if (div_done && div_quot > best_q) best_q <= div_quot;
				ST_FIN: begin
					if (div_start)
						phase_q <= phase_q + 2'd1;
					else if (div_done && phase_q == 2'd2) begin
						phase_q <= '0;
					end
				end
				ST_OUT: if (out_load) begin
					wptr_q <= '0;
					fill_q <= '0;
					wsum_q <= '0;
					calm_cnt_q <= '0;
					best_q <= MIN32;
					cnt_q <= '0;
					ssum_q <= '0;
					sqsum_q <= '0;
					smax_q <= MIN32;
					fault_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept_in) begin
			sample_q <= sample;
			calm_q <= calm_flag;
			last_q <= last_of_receptor;
		end
		if (state_q == ST_READ && phase_q == 2'd0)
			v_q <= sat32(scaled);
		if (state_q == ST_FIN && div_done && phase_q == 2'd1)
			mean_q <= (cnt_q == '0) ? 32'sd0 : div_quot;
		if (state_q == ST_FIN && div_done && phase_q == 2'd2)
			e2_q <= (cnt_q == '0) ? 64'd0 : div_uquot;
		if (out_load) begin
			res_avg_q <= best_q;
			res_mean_q <= mean_q;
			res_max_q <= smax_q;
			res_var_q <= var_full[63] ? {63{1'b1}} : var_full[62:0];
			res_fault_q <= fault_q;
		end
	end

	assign max_rolling_avg = res_avg_q;
	assign mean_value = res_mean_q;
	assign max_value = res_max_q;
	assign variance_value = res_var_q;
	assign divide_fault = res_fault_q;
endmodule
`default_nettype wire

// ===== rtl/rras_divider.sv =====
// restoring divider, one quotient bit per cycle
// signed 64 bit numerator rounded to nearest, or unsigned numerator floored,
// over an unsigned 64 bit divisor; uses rras_pkg
`default_nettype none
module rras_divider
	import rras_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic floor_div,
	input wire logic signed [63:0] num,
	input wire logic [63:0] den,
	output logic busy,
	output logic done,
	output logic signed [31:0] quot,
	output logic [63:0] uquot
);
	logic [6:0] cnt_q;
	logic [63:0] quo_q;
	logic [64:0] rem_q;
	logic [63:0] den_q;
	logic neg_q;
	logic neg_in;
	logic [64:0] trial;
	logic [64:0] mag;
	logic [64:0] rnd;
	logic [65:0] rsum;

	always_comb begin
		trial = {rem_q[63:0], quo_q[63]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// magnitude plus half the divisor is the dividend, giving rounding;
	// the floor mode takes the numerator as unsigned and adds nothing
	always_comb begin
		neg_in = !floor_div && num[63];
		mag = neg_in ? 65'(-{num[63], num}) : {1'b0, num};
		rsum = 66'(mag) + (floor_div ? 66'd0 : 66'(den >> 1));
		rnd = rsum[64:0];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= neg_in;
			den_q <= den;
			rem_q <= {64'd0, rnd[64]};
			quo_q <= rnd[63:0];
		end else if (busy) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	// the 65th dividend bit only ever sets a remainder bit; for the final
	// rounding it is folded into the first step through rem_q
	always_comb begin
		logic [63:0] q;
		logic [63:0] qc;
		q = quo_q;
		uquot = q;
		qc = (q > 64'h8000_0000) ? 64'h8000_0000 : q;
		if (neg_q)
			quot = sat32(-$signed(qc));
		else
			quot = sat32($signed(qc));
	end
endmodule
`default_nettype wire

// ===== rtl/rras_ring.sv =====
// ring window memory of scaled samples with calm flags
// synchronous single port read with registered read data, one write port; uses rras_pkg
`default_nettype none
module rras_ring
	import rras_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)(
	input wire logic clk,
	input wire logic rd_en,
	input wire logic [$clog2(WINDOW_DEPTH)-1:0] rd_addr,
	output logic [32:0] rd_data,
	input wire logic wr_en,
	input wire logic [$clog2(WINDOW_DEPTH)-1:0] wr_addr,
	input wire logic [32:0] wr_data
);
	logic [32:0] mem [WINDOW_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

// ===== bench/tb_receptor_rolling_average_stats.sv =====
// testbench for receptor_rolling_average_stats: directed and random series
// checked beat by beat against a behavioral scoreboard; uses rras_pkg
`timescale 1ns / 100ps
`default_nettype none
module tb_receptor_rolling_average_stats;
	import rras_pkg::*;

	localparam int DEPTH = 8192;
	localparam int SERIES_CAP = 1048576;
	localparam int WATCHDOG = 200000;
	localparam logic signed [63:0] LO32 = -64'sd2147483648;
	localparam logic signed [63:0] HI32 = 64'sd2147483647;

	typedef struct packed {
		logic signed [31:0] max_avg;
		logic signed [31:0] mean;
		logic signed [31:0] maxv;
		logic [62:0] var_q;
		logic fault;
	} stats_t;

	int errors = 0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// rounded divide, halves away from zero, saturated to 32 bits
	function automatic logic signed [63:0] div_near(input logic signed [63:0] num,
			input logic [63:0] d);
		logic [63:0] mag, q;
		logic signed [63:0] r;
		mag = num < 0 ? 64'(-num) : 64'(num);
		q = (mag + d / 2) / d;
		if (q > 64'h8000_0000)
			q = 64'h8000_0000;
		r = num < 0 ? -$signed(q) : $signed(q);
		if (r < LO32)
			r = LO32;
		if (r > HI32)
			r = HI32;
		return r;
	endfunction

	class stats_board;
		logic [13:0] win_cfg = 24;
		logic hourly = 1;
		logic [31:0] scale = 32'h0001_0000;
		logic signed [31:0] ring_val[DEPTH];
		logic ring_calm[DEPTH];
		int unsigned wptr, fill, calm_cnt, count;
		logic signed [63:0] wsum, ssum, best, smax;
		logic [63:0] sqsum;
		logic fault;
		stats_t pending[$];

		function void clear_window();
			wptr = 0; fill = 0; wsum = 0; calm_cnt = 0;
		endfunction

		function void clear_series();
			clear_window();
			best = LO32; smax = LO32; count = 0; ssum = 0; sqsum = 0; fault = 0;
		endfunction

		function void write_reg(input reg_idx_t idx, input logic [31:0] val);
			case (idx)
				REG_WINDOW_SIZE: begin
					win_cfg = val[13:0];
					clear_window();
				end
				REG_HOURLY_POLICY: hourly = val[0];
				REG_SCALE_FACTOR: scale = val;
				default: ;
			endcase
		endfunction

		function void note_sample(input logic signed [31:0] s, input logic calm,
				input logic last);
			int unsigned w;
			logic signed [63:0] p, v, mean;
			logic [63:0] d, sq, e2, m2, vr;
			stats_t r;
			w = win_cfg == 0 ? 1 : (win_cfg > DEPTH ? DEPTH : win_cfg);
			p = s * $signed({32'd0, scale}) + 64'sd32768;
			v = p >>> 16;
			if (v < LO32)
				v = LO32;
			if (v > HI32)
				v = HI32;
			if (wptr >= w)
				wptr = 0;
			if (fill >= w) begin
				wsum -= ring_val[wptr];
				calm_cnt -= ring_calm[wptr];
			end else
				fill++;
			ring_val[wptr] = v[31:0];
			ring_calm[wptr] = calm;
			wsum += v;
			calm_cnt += calm;
			wptr = (wptr + 1 >= w) ? 0 : wptr + 1;
			if (hourly) begin
				d = fill - calm_cnt;
				if (fill <= 24 && (3 * fill + 3) / 4 > d)
					d = (3 * fill + 3) / 4;
			end else
				d = fill;
			if (d == 0)
				fault = 1;
			else if (div_near(wsum, d) > best)
				best = div_near(wsum, d);
			if (v > smax)
				smax = v;
			if (count < SERIES_CAP) begin
				sq = 64'(v * v);
				count++;
				ssum += v;
				sqsum = (sqsum > ~sq) ? '1 : sqsum + sq;
			end
			if (!last)
				return;
			mean = count ? div_near(ssum, count) : 0;
			e2 = count ? sqsum / count : 0;
			m2 = 64'(mean * mean);
			vr = e2 > m2 ? e2 - m2 : 0;
			if (vr[63])
				vr = 64'h7fff_ffff_ffff_ffff;
			r.max_avg = best[31:0];
			r.mean = mean[31:0];
			r.maxv = smax[31:0];
			r.var_q = vr[62:0];
			r.fault = fault;
			pending = {pending, r};
			clear_series();
		endfunction

		task check_result(input stats_t got);
			stats_t want;
			if (pending.size() == 0) begin
				report("unexpected result beat", 64'd1, 64'd0);
				return;
			end
			want = pending.pop_front();
			if (got.max_avg !== want.max_avg)
				report("max_rolling_avg", 64'(got.max_avg), 64'(want.max_avg));
			if (got.mean !== want.mean)
				report("mean_value", 64'(got.mean), 64'(want.mean));
			if (got.maxv !== want.maxv)
				report("max_value", 64'(got.maxv), 64'(want.maxv));
			if (got.var_q !== want.var_q)
				report("variance_value", 64'(got.var_q), 64'(want.var_q));
			if (got.fault !== want.fault)
				report("divide_fault", 64'(got.fault), 64'(want.fault));
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;
	logic in_valid = 0, in_stall;
	logic signed [31:0] sample = 0;
	logic calm_flag = 0, last_of_receptor = 0;
	logic out_valid, out_stall = 0;
	logic signed [31:0] max_rolling_avg, mean_value, max_value;
	logic [62:0] variance_value;
	logic divide_fault;

	stats_board board = new();
	bit hold_long = 0;
	bit gaps_on = 1;
	int idle_cycles = 0;

	receptor_rolling_average_stats uut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		if (!gaps_on || $urandom_range(3) == 0)
			return 0;
		return $urandom_range(9) == 0 ? $urandom_range(60, 20) : $urandom_range(3);
	endfunction

	// receiver: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (hold_long)
			out_stall <= 1;
		else if (gaps_on)
			out_stall <= ($urandom_range(3) == 0) || ($urandom_range(40) == 0);
		else
			out_stall <= 0;
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			board.check_result('{max_rolling_avg, mean_value, max_value,
				variance_value, divide_fault});
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("[receptor_rolling_average_stats] ERROR");
			$finish;
		end
	end

	// valid stays up after a beat so that back to back beats need no drop
	task automatic send_beat(input logic signed [31:0] s, input logic c, input logic l);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		sample <= s;
		calm_flag <= c;
		last_of_receptor <= l;
		do
			@(posedge clk);
		while (in_stall);
		board.note_sample(s, c, l);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		// a non-last beat can still be dividing
		repeat (300) @(posedge clk);
	endtask

	task automatic write_cfg(input reg_idx_t idx, input logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		board.write_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_sample();
		case ($urandom_range(5))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return $signed(32'($urandom_range(20, 0) << 16));
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic random_series(input int len, input int calm_pct);
		for (int i = 0; i < len; i++)
			send_beat(rand_sample(), $urandom_range(99) < calm_pct, i == len - 1);
	endtask

	initial begin
		int sent;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: defaults, extremes, all calm (zero divisor), single-sample series
		send_beat(32'sh7fff_ffff, 0, 0);
		send_beat(32'sh8000_0000, 0, 0);
		send_beat(32'sh0001_8000, 1, 0);
		send_beat(-32'sh0000_8000, 0, 1);
		send_beat(32'sh0000_0000, 0, 1);
		drain();
		write_cfg(REG_WINDOW_SIZE, 0);
		write_cfg(REG_HOURLY_POLICY, 1);
		write_cfg(REG_SCALE_FACTOR, 32'hffff_ffff);
		send_beat(32'sh7fff_ffff, 1, 0);
		send_beat(32'sh0000_0001, 1, 0);
		send_beat(-32'sh0000_0001, 0, 1);
		drain();
		write_cfg(REG_SCALE_FACTOR, 0);
		write_cfg(REG_HOURLY_POLICY, 0);
		send_beat(32'sh1234_5678, 0, 0);
		send_beat(32'sh8000_0000, 1, 1);
		drain();
		write_cfg(REG_WINDOW_SIZE, 14'h3fff);
		write_cfg(REG_SCALE_FACTOR, 32'h0000_8000);
		write_cfg(REG_HOURLY_POLICY, 1);
		for (int i = 0; i < 30; i++)
			send_beat(32'sh0002_0000, 1, i == 29);
		drain();

		// long receiver hold-off while the sender keeps offering
		write_cfg(REG_WINDOW_SIZE, 3);
		write_cfg(REG_SCALE_FACTOR, 32'h0001_0000);
		hold_long = 1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_long = 0;
			end
			for (int i = 0; i < 8; i++)
				send_beat(rand_sample(), $urandom_range(1), 1);
		join
		drain();

		// random phases with different settings
		sent = 0;
		for (int ph = 0; sent < 650; ph++) begin
			case (ph % 4)
				0: write_cfg(REG_WINDOW_SIZE, $urandom_range(30, 1));
				1: write_cfg(REG_WINDOW_SIZE, $urandom_range(3) == 0 ? 8192 : $urandom_range(5));
				2: write_cfg(REG_HOURLY_POLICY, $urandom_range(1));
				default: write_cfg(REG_SCALE_FACTOR, $urandom_range(2) == 0 ? $urandom :
					$urandom_range(32'h0002_0000, 32'h0000_4000));
			endcase
			gaps_on = (ph % 5) != 3;
			for (int k = 0; k < 5; k++) begin
				int len;
				len = $urandom_range(12) == 0 ? $urandom_range(60, 25) : $urandom_range(12, 1);
				random_series(len, $urandom_range(2) == 0 ? 80 : 25);
				sent += len;
			end
			drain();
		end

		drain();
		if (errors == 0)
			$display("[receptor_rolling_average_stats] OK");
		else
			$display("[receptor_rolling_average_stats] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
